// File: hw/rtl/distance_vector_route_table_assert.svh
// Assertion macros shared by the route table RTL.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define DVRT_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("dvrt assertion failed");

// Antecedent one cycle, consequent the next cycle.
`define DVRT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dvrt assertion failed");

`endif

// File: hw/rtl/dvrt_pkg.sv
// Types, constants and codes of the distance-vector route table.
package dvrt_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam logic [7:0] METRIC_MAX = 8'd255;

   // opcodes
   localparam logic [2:0] OP_INSTALL = 3'd0;
   localparam logic [2:0] OP_DV      = 3'd1;
   localparam logic [2:0] OP_LOOKUP  = 3'd2;
   localparam logic [2:0] OP_SWEEP   = 3'd3;
   localparam logic [2:0] OP_EXPORT  = 3'd4;

   // result status codes
   localparam logic [2:0] ST_DONE         = 3'd0;
   localparam logic [2:0] ST_FORWARDED    = 3'd1;
   localparam logic [2:0] ST_NO_ROUTE     = 3'd2;
   localparam logic [2:0] ST_LOCAL        = 3'd3;
   localparam logic [2:0] ST_TTL_EXPIRED  = 3'd4;
   localparam logic [2:0] ST_FULL         = 3'd5;
   localparam logic [2:0] ST_EXPORT       = 3'd6;
   localparam logic [2:0] ST_EXPORT_EMPTY = 3'd7;

   // configuration register indexes
   localparam logic [1:0] CSR_MY_ID        = 2'd0;
   localparam logic [1:0] CSR_MAX_AGE      = 2'd1;
   localparam logic [1:0] CSR_METRIC_LIMIT = 2'd2;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  dest_id;
      logic [7:0]  neighbor_id;
      logic [7:0]  metric;
      logic [7:0]  ttl;
      logic [15:0] now;
      logic        end_of_vector;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] next_hop;
      logic [7:0] out_dest;
      logic [7:0] out_metric;
      logic [7:0] ttl_out;
      logic [5:0] removed_count;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  dest;
      logic [7:0]  metric;
      logic [7:0]  hop;
      logic [15:0] stamp;
   } entry_type;

   typedef struct packed {
      logic [7:0]  my_id;
      logic [15:0] max_age;
      logic [7:0]  metric_limit;
   } cfg_type;

   // per-entry verdicts of the compare unit
   typedef struct packed {
      logic       dest_hit;
      logic       dv_take;
      logic       stale_rm;
      logic       exp_ok;
      logic [7:0] cand;
   } eval_type;

endpackage

// File: hw/rtl/dvrt_table.sv
// Route storage: one write port, one registered read port.
module dvrt_table (
   input  logic                           clock,
   input  logic                           we,
   input  logic [dvrt_pkg::IDX_W-1:0]     wr_addr,
   input  dvrt_pkg::entry_type            wr_data,
   input  logic                           rd_en,
   input  logic [dvrt_pkg::IDX_W-1:0]     rd_addr,
   output dvrt_pkg::entry_type            rd_data
);

   dvrt_pkg::entry_type mem [dvrt_pkg::TABLE_DEPTH];
   dvrt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/dvrt_eval.sv
// Shared compare unit: judges one stored route against the current word.
module dvrt_eval (
   input  dvrt_pkg::entry_type entry,
   input  dvrt_pkg::req_type   req,
   input  dvrt_pkg::cfg_type   cfg,
   output dvrt_pkg::eval_type  verdict
);

   logic [15:0] age;
   logic [7:0]  cand;

   always_comb begin
      cand = (req.metric == dvrt_pkg::METRIC_MAX) ? dvrt_pkg::METRIC_MAX
                                                   : req.metric + 8'd1;
      age  = req.now - entry.stamp;
      verdict.cand     = cand;
      verdict.dest_hit = (entry.dest == req.dest_id);
      verdict.dv_take  = (entry.metric > cand) || (entry.hop == req.neighbor_id);
      verdict.stale_rm = (entry.dest != cfg.my_id)
                         && ((age > cfg.max_age) || (entry.metric > cfg.metric_limit));
      verdict.exp_ok   = (entry.hop != req.neighbor_id);
   end

endmodule

// File: hw/rtl/distance_vector_route_table.sv
// Distance-vector route table top level: sequencer, config registers, output register.
// Sequence: accept in idle, early answers in start, then a read and a judge state per table
//   entry visited; a swept-out entry adds a read of the last entry and a write into the hole.
// Throughput: one word at a time; lookups, installs and updates scan the N stored routes in
//   turn, one read at a time through the single registered read port of the table.
// Export results stream out, each one held until the next qualifying route is found or the scan ends.
// Reset (synchronous, active high) clears count, sequencer, output valid and config to defaults;
//   table contents are not cleared, only entries below the count are ever read.
module distance_vector_route_table (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dvrt_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dvrt_pkg::rsp_type   rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data
);

`include "distance_vector_route_table_assert.svh"

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_START  = 3'd1;  // early answers, scan setup
   localparam logic [2:0] S_RD     = 3'd2;  // issue read of entry idx
   localparam logic [2:0] S_CHK    = 3'd3;  // judge entry idx
   localparam logic [2:0] S_SW_RDL = 3'd4;  // sweep: read last entry
   localparam logic [2:0] S_SW_WR  = 3'd5;  // sweep: move last entry into the hole
   localparam logic [2:0] S_FIN    = 3'd6;  // scan exhausted

   logic [2:0]                  st_ff, st_in;
   dvrt_pkg::req_type           req_ff, req_in;
   dvrt_pkg::cfg_type           cfg_ff, cfg_in;
   logic [dvrt_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic [dvrt_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [5:0]                  rem_ff, rem_in;
   logic                        pend_v_ff, pend_v_in;
   logic [7:0]                  pend_dest_ff, pend_dest_in;
   logic [7:0]                  pend_met_ff, pend_met_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   dvrt_pkg::rsp_type           rsp_ff, rsp_in;

   logic                        tbl_we, tbl_rd_en;
   logic [dvrt_pkg::IDX_W-1:0]  tbl_wr_addr, tbl_rd_addr;
   dvrt_pkg::entry_type         tbl_wr_data, tbl_rd_data;
   dvrt_pkg::eval_type          verdict;

   logic                        out_free, emit;
   logic [dvrt_pkg::CNT_W-1:0]  cnt_m1;
   dvrt_pkg::rsp_type           res;
   logic                        csr_we;

   dvrt_table u_table (
      .clock   (clock),
      .we      (tbl_we),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   dvrt_eval u_eval (
      .entry   (tbl_rd_data),
      .req     (req_ff),
      .cfg     (cfg_ff),
      .verdict (verdict)
   );

   assign req_stall = (st_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt_m1    = cnt_ff - dvrt_pkg::CNT_W'(1);

   // config writes; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            dvrt_pkg::CSR_MY_ID:        cfg_in.my_id        = csr_data[7:0];
            dvrt_pkg::CSR_MAX_AGE:      cfg_in.max_age      = csr_data;
            dvrt_pkg::CSR_METRIC_LIMIT: cfg_in.metric_limit = csr_data[7:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      st_in        = st_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      pend_v_in    = pend_v_ff;
      pend_dest_in = pend_dest_ff;
      pend_met_in  = pend_met_ff;
      tbl_we       = 1'b0;
      tbl_wr_addr  = idx_ff[dvrt_pkg::IDX_W-1:0];
      tbl_wr_data  = '{dest: req_ff.dest_id, metric: req_ff.metric,
                       hop: req_ff.neighbor_id, stamp: req_ff.now};
      tbl_rd_en    = 1'b0;
      tbl_rd_addr  = idx_ff[dvrt_pkg::IDX_W-1:0];
      emit         = 1'b0;
      res          = '0;
      res.last     = 1'b1;

      unique case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               st_in  = S_START;
            end
         end
         S_START: begin
            idx_in    = '0;
            rem_in    = '0;
            pend_v_in = 1'b0;
            if (req_ff.opcode > dvrt_pkg::OP_EXPORT) begin
               res.status = dvrt_pkg::ST_DONE;
               emit       = out_free;
            end else if (req_ff.opcode == dvrt_pkg::OP_LOOKUP
                         && req_ff.dest_id == cfg_ff.my_id) begin
               res.status = dvrt_pkg::ST_LOCAL;
               emit       = out_free;
            end else if (req_ff.opcode == dvrt_pkg::OP_LOOKUP && req_ff.ttl <= 8'd1) begin
               res.status = dvrt_pkg::ST_TTL_EXPIRED;
               emit       = out_free;
            end else begin
               st_in = S_RD;
            end
            if (emit) begin
               st_in = S_IDLE;
            end
         end
         S_RD: begin
            if (idx_ff < cnt_ff) begin
               tbl_rd_en = 1'b1;
               st_in     = S_CHK;
            end else begin
               st_in = S_FIN;
            end
         end
         S_CHK: begin
            unique case (req_ff.opcode)
               dvrt_pkg::OP_INSTALL, dvrt_pkg::OP_DV, dvrt_pkg::OP_LOOKUP: begin
                  if (verdict.dest_hit) begin
                     if (out_free) begin
                        emit = 1'b1;
                        st_in = S_IDLE;
                        if (req_ff.opcode == dvrt_pkg::OP_LOOKUP) begin
                           res.status   = dvrt_pkg::ST_FORWARDED;
                           res.next_hop = tbl_rd_data.hop;
                           res.ttl_out  = req_ff.ttl - 8'd1;
                        end else begin
                           res.status = dvrt_pkg::ST_DONE;
                           if (req_ff.opcode == dvrt_pkg::OP_INSTALL) begin
                              tbl_we = 1'b1;
                           end else begin
                              tbl_we             = verdict.dv_take;
                              tbl_wr_data.metric = verdict.cand;
                           end
                        end
                     end
                  end else begin
                     idx_in = idx_ff + dvrt_pkg::CNT_W'(1);
                     st_in  = S_RD;
                  end
               end
               dvrt_pkg::OP_SWEEP: begin
                  if (verdict.stale_rm) begin
                     st_in = S_SW_RDL;
                  end else begin
                     idx_in = idx_ff + dvrt_pkg::CNT_W'(1);
                     st_in  = S_RD;
                  end
               end
               dvrt_pkg::OP_EXPORT: begin
                  if (!verdict.exp_ok) begin
                     idx_in = idx_ff + dvrt_pkg::CNT_W'(1);
                     st_in  = S_RD;
                  end else if (!pend_v_ff || out_free) begin
                     // previous find goes out, this one is held until we know if it is last
                     emit           = pend_v_ff;
                     res.status     = dvrt_pkg::ST_EXPORT;
                     res.out_dest   = pend_dest_ff;
                     res.out_metric = pend_met_ff;
                     res.last       = 1'b0;
                     pend_v_in      = 1'b1;
                     pend_dest_in   = tbl_rd_data.dest;
                     pend_met_in    = tbl_rd_data.metric;
                     idx_in         = idx_ff + dvrt_pkg::CNT_W'(1);
                     st_in          = S_RD;
                  end
               end
               default: begin
                  st_in = S_FIN;
               end
            endcase
         end
         S_SW_RDL: begin
            tbl_rd_en   = 1'b1;
            tbl_rd_addr = cnt_m1[dvrt_pkg::IDX_W-1:0];
            st_in       = S_SW_WR;
         end
         S_SW_WR: begin
            // rechecks the moved entry in the same slot
            tbl_we      = 1'b1;
            tbl_wr_data = tbl_rd_data;
            cnt_in      = cnt_m1;
            rem_in      = (rem_ff == 6'd63) ? rem_ff : rem_ff + 6'd1;
            st_in       = S_RD;
         end
         S_FIN: begin
            if (out_free) begin
               emit  = 1'b1;
               st_in = S_IDLE;
               unique case (req_ff.opcode)
                  dvrt_pkg::OP_INSTALL, dvrt_pkg::OP_DV: begin
                     if (cnt_ff < dvrt_pkg::CNT_W'(dvrt_pkg::TABLE_DEPTH)) begin
                        res.status  = dvrt_pkg::ST_DONE;
                        tbl_we      = 1'b1;
                        tbl_wr_addr = cnt_ff[dvrt_pkg::IDX_W-1:0];
                        if (req_ff.opcode == dvrt_pkg::OP_DV) begin
                           tbl_wr_data.metric = verdict.cand;
                        end
                        cnt_in = cnt_ff + dvrt_pkg::CNT_W'(1);
                     end else begin
                        res.status = dvrt_pkg::ST_FULL;
                     end
                  end
                  dvrt_pkg::OP_LOOKUP: res.status = dvrt_pkg::ST_NO_ROUTE;
                  dvrt_pkg::OP_SWEEP: begin
                     res.status        = dvrt_pkg::ST_DONE;
                     res.removed_count = rem_ff;
                  end
                  dvrt_pkg::OP_EXPORT: begin
                     if (pend_v_ff) begin
                        res.status     = dvrt_pkg::ST_EXPORT;
                        res.out_dest   = pend_dest_ff;
                        res.out_metric = pend_met_ff;
                     end else begin
                        res.status = dvrt_pkg::ST_EXPORT_EMPTY;
                     end
                  end
                  default: res.status = dvrt_pkg::ST_DONE;
               endcase
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_v_ff    <= 1'b0;
         cfg_ff       <= '{my_id: 8'd0, max_age: 16'd5, metric_limit: 8'd16};
      end else begin
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_v_ff    <= pend_v_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      idx_ff       <= idx_in;
      rem_ff       <= rem_in;
      pend_dest_ff <= pend_dest_in;
      pend_met_ff  <= pend_met_in;
      rsp_ff       <= rsp_in;
   end

   // checks
   `DVRT_ASSERT_ALWAYS(a_count_bound, cnt_ff <= dvrt_pkg::CNT_W'(dvrt_pkg::TABLE_DEPTH))
   `DVRT_ASSERT_NEXT(a_accept_starts, req_valid && !req_stall, st_ff == S_START)
   `DVRT_ASSERT_ALWAYS(a_write_states, !tbl_we || st_ff == S_CHK || st_ff == S_SW_WR || st_ff == S_FIN)

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the distance-vector route table.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   dvrt_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   dvrt_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [1:0]        csr_index;
   logic [15:0]       csr_data;

   distance_vector_route_table u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Mirror of the route table and the node registers.
   logic [7:0]          own_id;
   logic [15:0]         age_limit;
   logic [7:0]          metric_cap;
   int                  n_routes;
   dvrt_pkg::entry_type routes [dvrt_pkg::TABLE_DEPTH];

   dvrt_pkg::req_type pending_words [$];    // words waiting for the driver
   dvrt_pkg::rsp_type expected_rsps [$];    // results still owed by the block
   int      errors;
   int      send_idle_pct;        // sender idle percentage
   int      recv_idle_pct;        // receiver stall percentage
   int      sent_words;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic dvrt_pkg::rsp_type make_rsp(logic [2:0] st);
      dvrt_pkg::rsp_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic int find_dest(logic [7:0] d);
      for (int i = 0; i < n_routes; i++)
         if (routes[i].dest == d) return i;
      return -1;
   endfunction

   // Advances the mirror by one word and queues the results it owes.
   function automatic void route_predict(dvrt_pkg::req_type w);
      int        idx;
      int        hits;
      int        i;
      int        removed;
      logic [7:0]  cand;
      logic [15:0] age;
      dvrt_pkg::rsp_type r;
      idx = find_dest(w.dest_id);
      case (w.opcode)
         dvrt_pkg::OP_INSTALL, dvrt_pkg::OP_DV: begin
            cand = (w.opcode == dvrt_pkg::OP_DV)
                   ? ((w.metric == 8'd255) ? 8'd255 : w.metric + 8'd1) : w.metric;
            if (idx < 0) begin
               if (n_routes >= dvrt_pkg::TABLE_DEPTH) begin
                  expected_rsps.push_back(make_rsp(dvrt_pkg::ST_FULL));
                  return;
               end
               routes[n_routes] = '{w.dest_id, cand, w.neighbor_id, w.now};
               n_routes++;
            end else if (w.opcode == dvrt_pkg::OP_INSTALL || routes[idx].metric > cand ||
                         routes[idx].hop == w.neighbor_id) begin
               routes[idx] = '{w.dest_id, cand, w.neighbor_id, w.now};
            end
            expected_rsps.push_back(make_rsp(dvrt_pkg::ST_DONE));
         end
         dvrt_pkg::OP_LOOKUP: begin
            if (w.dest_id == own_id) r = make_rsp(dvrt_pkg::ST_LOCAL);
            else if (w.ttl <= 8'd1) r = make_rsp(dvrt_pkg::ST_TTL_EXPIRED);
            else if (idx < 0) r = make_rsp(dvrt_pkg::ST_NO_ROUTE);
            else begin
               r = make_rsp(dvrt_pkg::ST_FORWARDED);
               r.next_hop = routes[idx].hop;
               r.ttl_out = w.ttl - 8'd1;
            end
            expected_rsps.push_back(r);
         end
         dvrt_pkg::OP_SWEEP: begin
            // a removed slot takes the last entry, which is then checked in place
            i = 0;
            removed = 0;
            while (i < n_routes) begin
               age = w.now - routes[i].stamp;
               if (routes[i].dest != own_id &&
                   (age > age_limit || routes[i].metric > metric_cap)) begin
                  routes[i] = routes[n_routes - 1];
                  n_routes--;
                  if (removed < 63) removed++;
               end else i++;
            end
            r = make_rsp(dvrt_pkg::ST_DONE);
            r.removed_count = removed[5:0];
            expected_rsps.push_back(r);
         end
         dvrt_pkg::OP_EXPORT: begin
            // split horizon: skip routes learned from the target neighbor
            hits = 0;
            for (i = 0; i < n_routes && hits < 32; i++)
               if (routes[i].hop != w.neighbor_id) begin
                  r = '0;
                  r.status = dvrt_pkg::ST_EXPORT;
                  r.out_dest = routes[i].dest;
                  r.out_metric = routes[i].metric;
                  expected_rsps.push_back(r);
                  hits++;
               end
            if (hits == 0) expected_rsps.push_back(make_rsp(dvrt_pkg::ST_EXPORT_EMPTY));
            else expected_rsps[$].last = 1'b1;
         end
         default: expected_rsps.push_back(make_rsp(dvrt_pkg::ST_DONE));
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
      errors++;
   endtask

   // Driver: one word at a time from the pending queue, changes on falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else if (req_valid && req_stall) begin
         // hold the stalled word
      end else if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
         req_valid <= 1'b1;
         req_data  <= pending_words.pop_front();
      end else begin
         req_valid <= 1'b0;
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Prediction happens at acceptance so the mirror follows block order.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         route_predict(req_data);
         sent_words++;
      end
   end

   // Monitor: compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      dvrt_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected result", 32'(rsp_data.status), 32'd0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status != want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.next_hop != want.next_hop)
               report_mismatch("next_hop", 32'(rsp_data.next_hop), 32'(want.next_hop));
            if (rsp_data.out_dest != want.out_dest)
               report_mismatch("out_dest", 32'(rsp_data.out_dest), 32'(want.out_dest));
            if (rsp_data.out_metric != want.out_metric)
               report_mismatch("out_metric", 32'(rsp_data.out_metric),
                               32'(want.out_metric));
            if (rsp_data.ttl_out != want.ttl_out)
               report_mismatch("ttl_out", 32'(rsp_data.ttl_out), 32'(want.ttl_out));
            if (rsp_data.removed_count != want.removed_count)
               report_mismatch("removed_count", 32'(rsp_data.removed_count),
                               32'(want.removed_count));
            if (rsp_data.last != want.last)
               report_mismatch("last", 32'(rsp_data.last), 32'(want.last));
         end
      end
   end

   function automatic dvrt_pkg::req_type make_word(logic [2:0] op, logic [7:0] d,
                                                   logic [7:0] nb, logic [7:0] m,
                                                   logic [7:0] t, logic [15:0] nw);
      dvrt_pkg::req_type w;
      w.opcode = op;
      w.dest_id = d;
      w.neighbor_id = nb;
      w.metric = m;
      w.ttl = t;
      w.now = nw;
      w.end_of_vector = 1'($urandom_range(1));
      return w;
   endfunction

   // Waits until every queued word went in and every result came back.
   task automatic drain();
      while (pending_words.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         dvrt_pkg::CSR_MY_ID:        own_id = val[7:0];
         dvrt_pkg::CSR_MAX_AGE:      age_limit = val;
         dvrt_pkg::CSR_METRIC_LIMIT: metric_cap = val[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random traffic: mostly well-formed vectors over a small set of
   // destinations and neighbors so that routes hit, improve and age out.
   task automatic queue_random(int count, logic [15:0] base_time);
      int          op_pick;
      logic [15:0] clk_now;
      clk_now = base_time;
      for (int k = 0; k < count; k++) begin
         op_pick = $urandom_range(99);
         clk_now += 16'($urandom_range(2));
         if (op_pick < 30)
            pending_words.push_back(make_word(dvrt_pkg::OP_DV, 8'($urandom_range(40)),
               8'($urandom_range(5)),
               ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(20)),
               8'd0, clk_now));
         else if (op_pick < 45)
            pending_words.push_back(make_word(dvrt_pkg::OP_INSTALL, 8'($urandom_range(40)),
               8'($urandom_range(5)), 8'($urandom_range(24)), 8'd0, clk_now));
         else if (op_pick < 68)
            pending_words.push_back(make_word(dvrt_pkg::OP_LOOKUP, 8'($urandom_range(42)),
               8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
               clk_now));
         else if (op_pick < 78)
            pending_words.push_back(make_word(dvrt_pkg::OP_SWEEP, 8'($urandom_range(255)),
               8'($urandom_range(255)), 8'($urandom_range(255)), 8'd0, clk_now));
         else if (op_pick < 90)
            pending_words.push_back(make_word(dvrt_pkg::OP_EXPORT, 8'($urandom_range(255)),
               8'($urandom_range(6)), 8'd0, 8'd0, clk_now));
         else
            pending_words.push_back(make_word(3'($urandom_range(7)), 8'($urandom_range(255)),
               8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
               16'($urandom_range(65535))));
      end
   endtask

   initial begin
      errors = 0;
      sent_words = 0;
      send_idle_pct = 34;
      recv_idle_pct = 57;
      own_id = 8'd0;
      age_limit = 16'd5;
      metric_cap = 8'd16;
      n_routes = 0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = dvrt_pkg::CSR_MY_ID;
      csr_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under reset defaults.
      pending_words.push_back(make_word(dvrt_pkg::OP_EXPORT, 0, 0, 0, 0, 0));   // empty export
      pending_words.push_back(make_word(dvrt_pkg::OP_LOOKUP, 8'd0, 0, 0, 8'd0, 0)); // local
      pending_words.push_back(make_word(dvrt_pkg::OP_LOOKUP, 8'd9, 0, 0, 8'd1, 0)); // ttl out
      pending_words.push_back(make_word(dvrt_pkg::OP_LOOKUP, 8'd9, 0, 0, 8'd255, 0)); // none
      pending_words.push_back(make_word(dvrt_pkg::OP_INSTALL, 8'd9, 8'd3, 8'd4, 0, 16'd10));
      pending_words.push_back(make_word(dvrt_pkg::OP_INSTALL, 8'd9, 8'd255, 8'd255, 0,
                                        16'hFFFF));
      pending_words.push_back(make_word(dvrt_pkg::OP_DV, 8'd255, 8'd7, 8'd255, 0, 16'd0));
      pending_words.push_back(make_word(dvrt_pkg::OP_DV, 8'd255, 8'd8, 8'd2, 0, 16'd1)); // better
      pending_words.push_back(make_word(dvrt_pkg::OP_DV, 8'd255, 8'd9, 8'd7, 0, 16'd1)); // worse
      pending_words.push_back(make_word(dvrt_pkg::OP_DV, 8'd255, 8'd8, 8'd9, 0, 16'd2)); // same
      pending_words.push_back(make_word(dvrt_pkg::OP_LOOKUP, 8'd255, 0, 0, 8'd2, 0));
      pending_words.push_back(make_word(dvrt_pkg::OP_EXPORT, 0, 8'd8, 0, 0, 0));
      pending_words.push_back(make_word(dvrt_pkg::OP_EXPORT, 0, 8'd1, 0, 0, 0));
      pending_words.push_back(make_word(3'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
      pending_words.push_back(make_word(3'd7, 0, 0, 0, 0, 0));
      // fill the table and overflow it
      for (int k = 0; k < 33; k++)
         pending_words.push_back(make_word((k % 2) ? dvrt_pkg::OP_DV : dvrt_pkg::OP_INSTALL,
            8'(100 + k), 8'd1, 8'd1, 0, 16'd3));
      pending_words.push_back(make_word(dvrt_pkg::OP_EXPORT, 0, 8'd2, 0, 0, 0)); // 32 results
      pending_words.push_back(make_word(dvrt_pkg::OP_SWEEP, 0, 0, 0, 0, 16'd65000)); // wrap
      drain();

      // Own route survives a sweep; sweep also catches over-limit metrics.
      write_csr(dvrt_pkg::CSR_MY_ID, 16'd50);
      write_csr(dvrt_pkg::CSR_MAX_AGE, 16'hFFFF);
      write_csr(dvrt_pkg::CSR_METRIC_LIMIT, 16'd0);
      pending_words.push_back(make_word(dvrt_pkg::OP_INSTALL, 8'd50, 8'd1, 8'd9, 0, 16'd0));
      pending_words.push_back(make_word(dvrt_pkg::OP_INSTALL, 8'd51, 8'd1, 8'd9, 0, 16'd0));
      pending_words.push_back(make_word(dvrt_pkg::OP_INSTALL, 8'd52, 8'd1, 8'd0, 0, 16'd0));
      pending_words.push_back(make_word(dvrt_pkg::OP_SWEEP, 0, 0, 0, 0, 16'd1));
      pending_words.push_back(make_word(dvrt_pkg::OP_LOOKUP, 8'd50, 0, 0, 8'd0, 0));
      drain();

      // Random phases across several register settings and idling profiles.
      write_csr(dvrt_pkg::CSR_MY_ID, 16'd7);
      write_csr(dvrt_pkg::CSR_MAX_AGE, 16'd6);
      write_csr(dvrt_pkg::CSR_METRIC_LIMIT, 16'd16);
      queue_random(45, 16'd200);
      drain();

      send_idle_pct = 57;
      recv_idle_pct = 34;
      write_csr(dvrt_pkg::CSR_MY_ID, 16'd255);
      write_csr(dvrt_pkg::CSR_MAX_AGE, 16'd0);
      write_csr(dvrt_pkg::CSR_METRIC_LIMIT, 16'd255);
      queue_random(45, 16'hFFE0);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(dvrt_pkg::CSR_MY_ID, 16'd0);
      write_csr(dvrt_pkg::CSR_MAX_AGE, 16'd20);
      write_csr(dvrt_pkg::CSR_METRIC_LIMIT, 16'd12);
      queue_random(45, 16'd1000);
      drain();

      if (errors == 0) begin
         $display("distance_vector_route_table: match");
      end else begin
         $display("distance_vector_route_table: mismatch");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("distance_vector_route_table: mismatch");
      $finish;
   end

endmodule
